// ----- src/bmtp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmtp_pkg
// Shared types and constants of the budgeted memory tier placer.
// ----------------------------------------------------------------------------
package bmtp_pkg;

  localparam int DataW = 32;
  localparam int BankW = 13;
  localparam int BlkW  = 21;
  localparam int CostW = 40;
  localparam int CurW  = 3;
  localparam int IdxW  = 3;
  localparam int ModeW = 2;

  typedef enum logic [1:0] {
    KIND_LUTRAM = 2'd0,
    KIND_URAM   = 2'd1,
    KIND_BRAM   = 2'd2,
    KIND_DRAM   = 2'd3
  } kind_t;

  localparam logic [CurW-1:0] CUR_DRAM    = 3'd3;
  localparam logic [CurW-1:0] CUR_UNKNOWN = 3'd4;

  typedef enum logic [IdxW-1:0] {
    REG_DRAM_THRESH   = 3'd0,
    REG_BRAM_BUDGET   = 3'd1,
    REG_URAM_BUDGET   = 3'd2,
    REG_LUTRAM_BUDGET = 3'd3,
    REG_LUTRAM_MAX    = 3'd4,
    REG_BRAM_BLOCK    = 3'd5,
    REG_URAM_BLOCK    = 3'd6,
    REG_MODE          = 3'd7
  } reg_idx_t;

  localparam logic [DataW-1:0] LUTRAM_MAX_RESET = 32'd256;
  localparam logic [BlkW-1:0]  BRAM_BLOCK_RESET = 21'd4608;
  localparam logic [BlkW-1:0]  URAM_BLOCK_RESET = 21'd36864;
  localparam logic [DataW-1:0] SAT_MAX          = '1;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } div_rsp_t;

endpackage

// ----- src/bmtp_div.sv -----
// ----------------------------------------------------------------------------
// bmtp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmtp_div (
  input  logic               clk,
  input  logic               rst,
  input  bmtp_pkg::div_req_t req,
  output bmtp_pkg::div_rsp_t rsp
);
  import bmtp_pkg::*;

  localparam int CntW = $clog2(DataW + 1);

  logic [DataW-1:0] quot;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] dsr;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;

  assign shifted = {rem, quot[DataW-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= CntW'(DataW);
      end else if (busy) begin
        if (!diff[DataW]) begin
          rem  <= diff[DataW-1:0];
          quot <= {quot[DataW-2:0], 1'b1};
        end else begin
          rem  <= shifted[DataW-1:0];
          quot <= {quot[DataW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  a_busy_counts: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0) else $error("divider busy with empty count");

endmodule

// ----- src/budgeted_memory_tier_placer.sv -----
// ----------------------------------------------------------------------------
// budgeted_memory_tier_placer
// Places buffer requests in LUTRAM, URAM, BRAM or DRAM under byte budgets.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    start_run .. current_kind
//   out      output     out_valid/out_ready  placed_kind, six byte counters
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// One request passes from one transfer to the next through the idle state
// of the transfer, three divisions on the shared divider (bytes per bank,
// URAM rounding, BRAM rounding), two multiply states, one decision state
// and one output load.
// Reset clears the counters and loads the register defaults.
// in_ready is high only in idle; a finished result waits for the output
// register while that register still holds an unmoved result.
// ----------------------------------------------------------------------------
module budgeted_memory_tier_placer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         start_run,
  input  logic [bmtp_pkg::DataW-1:0]   element_count,
  input  logic [bmtp_pkg::DataW-1:0]   byte_size,
  input  logic [bmtp_pkg::BankW-1:0]   bank_count,
  input  logic                         is_constant,
  input  logic [bmtp_pkg::CurW-1:0]    current_kind,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   placed_kind,
  output logic [bmtp_pkg::DataW-1:0]   lutram_used_bytes,
  output logic [bmtp_pkg::DataW-1:0]   uram_used_bytes,
  output logic [bmtp_pkg::DataW-1:0]   bram_used_bytes,
  output logic [bmtp_pkg::DataW-1:0]   rebalance_overflow_bytes,
  output logic [bmtp_pkg::DataW-1:0]   constant_overflow_bytes,
  output logic [bmtp_pkg::DataW-1:0]   external_overflow_bytes,
  input  logic                         cfg_we,
  input  logic [bmtp_pkg::IdxW-1:0]    cfg_index,
  input  logic [bmtp_pkg::DataW-1:0]   cfg_data
);
  import bmtp_pkg::*;

  localparam int RndW = DataW + 1;
  localparam int ProdW = BankW + RndW;

  typedef enum logic [2:0] {
    S_IDLE, S_D1, S_D2, S_D3, S_MU, S_MB, S_DEC, S_OUT
  } state_t;

  state_t state;

  logic [DataW-1:0] thr, bram_bud, uram_bud, lut_bud, lut_max;
  logic [BlkW-1:0]  bram_blk, uram_blk;
  logic [ModeW-1:0] mode;

  logic [DataW-1:0] lut_used, uram_used, bram_used;
  logic [DataW-1:0] rebal_ovf, const_ovf, ext_ovf;

  logic [DataW-1:0] elems, bytes;
  logic [BankW-1:0] banks;
  logic             is_const;
  logic [CurW-1:0]  cur;
  logic [DataW-1:0] bb;
  logic [RndW-1:0]  urnd, brnd;
  logic [CostW-1:0] ucost, bcost;
  kind_t            res_kind;

  div_req_t dreq;
  div_rsp_t drsp;

  logic             accept;
  logic [DataW-1:0] ugrain, bgrain, bb_now;
  logic [RndW-1:0]  rnd_now;
  logic [ProdW-1:0] prod;
  logic [CostW-1:0] cost_now;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign ugrain   = (uram_blk == '0) ? DataW'(1) : DataW'(uram_blk);
  assign bgrain   = (bram_blk == '0) ? DataW'(1) : DataW'(bram_blk);
  assign bb_now   = drsp.quot + DataW'(drsp.rem != '0);

  always_comb begin
    rnd_now = RndW'(bb);
    if (drsp.rem != '0) begin
      rnd_now = RndW'(bb) + RndW'(((state == S_D2) ? ugrain : bgrain) - drsp.rem);
    end
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = bb;
    dreq.divisor  = bgrain;
    unique case (state)
      S_IDLE: begin
        dreq.start    = accept;
        dreq.dividend = byte_size;
        dreq.divisor  = (bank_count == '0) ? DataW'(1) : DataW'(bank_count);
      end
      S_D1: begin
        dreq.start    = drsp.done;
        dreq.dividend = bb_now;
        dreq.divisor  = ugrain;
      end
      S_D2: begin
        dreq.start    = drsp.done;
        dreq.dividend = bb;
        dreq.divisor  = bgrain;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  bmtp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign prod     = ProdW'(banks) * ProdW'((state == S_MU) ? urnd : brnd);
  assign cost_now = is_const ? CostW'(prod) : CostW'({prod, 1'b0});

  // decision
  logic             rebal, allow;
  logic [RndW-1:0]  lneed;
  logic             lut_fit, u_ok, u_big, u_fit, b_fit, decided;
  kind_t            pick, kind_d;
  logic [DataW-1:0] lut_n, uram_n, bram_n, rebal_n, const_n, ext_n;
  logic [CostW:0]   ovf_sum;
  logic [DataW-1:0] ovf_sat;

  always_comb begin
    rebal   = mode[0];
    allow   = mode[1];
    lneed   = is_const ? {1'b0, bytes} : {bytes, 1'b0};
    lut_fit = (bytes <= lut_max) &&
              ((RndW + 1)'(lut_used) + (RndW + 1)'(lneed) <= (RndW + 1)'(lut_bud));
    u_ok    = (uram_blk != '0);
    u_big   = (bytes >= DataW'(uram_blk));
    u_fit   = (CostW + 1)'(uram_used) + (CostW + 1)'(ucost) <= (CostW + 1)'(uram_bud);
    b_fit   = (CostW + 1)'(bram_used) + (CostW + 1)'(bcost) <= (CostW + 1)'(bram_bud);
    if (lut_fit) pick = KIND_LUTRAM;
    else if (u_ok && u_big && u_fit) pick = KIND_URAM;
    else if (b_fit) pick = KIND_BRAM;
    else if (u_ok && !u_big && u_fit) pick = KIND_URAM;
    else pick = KIND_DRAM;
    decided = rebal ? (cur == CUR_DRAM) : (allow && !is_const && elems >= thr);

    ovf_sum = '0;
    ovf_sat = '0;
    lut_n   = lut_used;
    uram_n  = uram_used;
    bram_n  = bram_used;
    rebal_n = rebal_ovf;
    const_n = const_ovf;
    ext_n   = ext_ovf;
    kind_d  = KIND_BRAM;
    if (decided) begin
      kind_d = KIND_DRAM;
    end else if (bytes != '0) begin
      kind_d = pick;
      unique case (pick)
        KIND_LUTRAM: lut_n  = lut_used + lneed[DataW-1:0];
        KIND_URAM:   uram_n = uram_used + ucost[DataW-1:0];
        KIND_BRAM:   bram_n = bram_used + bcost[DataW-1:0];
        default: begin
          if (rebal) begin
            ovf_sum = (CostW + 1)'(rebal_ovf) + (CostW + 1)'(bcost);
          end else if (is_const) begin
            ovf_sum = (CostW + 1)'(const_ovf) + (CostW + 1)'(bcost);
          end else begin
            ovf_sum = (CostW + 1)'(ext_ovf) + (CostW + 1)'(bcost);
          end
          ovf_sat = (ovf_sum > (CostW + 1)'(SAT_MAX)) ? SAT_MAX : ovf_sum[DataW-1:0];
          if (rebal) begin
            kind_d  = (cur == CUR_UNKNOWN) ? KIND_BRAM : kind_t'(cur[1:0]);
            rebal_n = ovf_sat;
          end else if (is_const) begin
            kind_d  = KIND_BRAM;
            const_n = ovf_sat;
          end else if (!allow) begin
            kind_d = KIND_BRAM;
            ext_n  = ovf_sat;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      thr       <= '0;
      bram_bud  <= '0;
      uram_bud  <= '0;
      lut_bud   <= '0;
      lut_max   <= LUTRAM_MAX_RESET;
      bram_blk  <= BRAM_BLOCK_RESET;
      uram_blk  <= URAM_BLOCK_RESET;
      mode      <= '0;
      lut_used  <= '0;
      uram_used <= '0;
      bram_used <= '0;
      rebal_ovf <= '0;
      const_ovf <= '0;
      ext_ovf   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DRAM_THRESH:   thr      <= cfg_data;
          REG_BRAM_BUDGET:   bram_bud <= cfg_data;
          REG_URAM_BUDGET:   uram_bud <= cfg_data;
          REG_LUTRAM_BUDGET: lut_bud  <= cfg_data;
          REG_LUTRAM_MAX:    lut_max  <= cfg_data;
          REG_BRAM_BLOCK:    bram_blk <= cfg_data[BlkW-1:0];
          REG_URAM_BLOCK:    uram_blk <= cfg_data[BlkW-1:0];
          REG_MODE:          mode     <= cfg_data[ModeW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            elems    <= element_count;
            bytes    <= byte_size;
            banks    <= (bank_count == '0) ? BankW'(1) : bank_count;
            is_const <= is_constant;
            cur      <= (current_kind > CUR_UNKNOWN) ? CUR_UNKNOWN : current_kind;
            if (start_run) begin
              lut_used  <= '0;
              uram_used <= '0;
              bram_used <= '0;
              rebal_ovf <= '0;
              const_ovf <= '0;
              ext_ovf   <= '0;
            end
            state <= S_D1;
          end
        end
        S_D1: begin
          if (drsp.done) begin
            bb    <= bb_now;
            state <= S_D2;
          end
        end
        S_D2: begin
          if (drsp.done) begin
            urnd  <= rnd_now;
            state <= S_D3;
          end
        end
        S_D3: begin
          if (drsp.done) begin
            brnd  <= rnd_now;
            state <= S_MU;
          end
        end
        S_MU: begin
          ucost <= cost_now;
          state <= S_MB;
        end
        S_MB: begin
          bcost <= cost_now;
          state <= S_DEC;
        end
        S_DEC: begin
          res_kind  <= kind_d;
          lut_used  <= lut_n;
          uram_used <= uram_n;
          bram_used <= bram_n;
          rebal_ovf <= rebal_n;
          const_ovf <= const_n;
          ext_ovf   <= ext_n;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            placed_kind              <= res_kind;
            lutram_used_bytes        <= lut_used;
            uram_used_bytes          <= uram_used;
            bram_used_bytes          <= bram_used;
            rebalance_overflow_bytes <= rebal_ovf;
            constant_overflow_bytes  <= const_ovf;
            external_overflow_bytes  <= ext_ovf;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready) else $error("ready stayed high after a transfer");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> (state == S_D1 || state == S_D2 || state == S_D3))
    else $error("divider result outside a division step");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result shown without an output load");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for budgeted_memory_tier_placer. Placement requests are
// sent as directed cases and then as random ones under a range of register
// settings. Each response is checked against a behavioral copy of the tier
// choice, the per-tier usage and the saturating overflow totals. Both sides
// of the request/response path idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bmtp_pkg::*;

  typedef logic [63:0] u64;

  typedef struct {
    logic                start_run;
    logic [DataW-1:0]    element_count;
    logic [DataW-1:0]    byte_size;
    logic [BankW-1:0]    bank_count;
    logic                is_constant;
    logic [CurW-1:0]     current_kind;
  } request_t;

  typedef struct {
    kind_t               kind;
    logic [DataW-1:0]    lutram_used;
    logic [DataW-1:0]    uram_used;
    logic [DataW-1:0]    bram_used;
    logic [DataW-1:0]    rebal_ovf;
    logic [DataW-1:0]    const_ovf;
    logic [DataW-1:0]    ext_ovf;
  } placement_t;

  localparam int IdleLimit = 20000;
  localparam u64 Max32     = 64'hFFFF_FFFF;

  logic             clk, rst;
  logic             in_valid, in_ready, out_valid, out_ready;
  logic             start_run, is_constant;
  logic [DataW-1:0] element_count, byte_size;
  logic [BankW-1:0] bank_count;
  logic [CurW-1:0]  current_kind;
  logic [1:0]       placed_kind;
  logic [DataW-1:0] lutram_used_bytes, uram_used_bytes, bram_used_bytes;
  logic [DataW-1:0] rebalance_overflow_bytes, constant_overflow_bytes;
  logic [DataW-1:0] external_overflow_bytes;
  logic             cfg_we;
  logic [IdxW-1:0]  cfg_index;
  logic [DataW-1:0] cfg_data;

  budgeted_memory_tier_placer dut (.*);

  // register mirror
  u64 thresh_m, bram_budget_m, uram_budget_m, lutram_budget_m;
  u64 lutram_max_m, bram_blk_m, uram_blk_m, mode_m;
  // counter mirror
  u64 lutram_use, uram_use, bram_use, rebal_ovf, const_ovf, ext_ovf;

  placement_t expected_q[$];
  int errors = 0, sent = 0, checked = 0, settings = 0;
  int kind_hits[4] = '{0, 0, 0, 0};
  int burst_left = 0, max_gap = 6;
  int hold_left = 0, stall_style = 0, stall_phase = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic u64 rounded_cost(u64 copies, u64 banks, u64 bytes, u64 grain);
    u64 per_bank;
    u64 g;
    g = (grain == 0) ? 64'd1 : grain;
    per_bank = (bytes + banks - 1) / banks;
    return copies * banks * (((per_bank + g - 1) / g) * g);
  endfunction

  function automatic kind_t choose_tier(u64 bytes, u64 banks, u64 copies);
    u64 need, uneed;
    uneed = 0;
    if (bytes <= lutram_max_m && lutram_use + copies * bytes <= lutram_budget_m) begin
      lutram_use += copies * bytes;
      return KIND_LUTRAM;
    end
    if (uram_blk_m != 0) uneed = rounded_cost(copies, banks, bytes, uram_blk_m);
    if (uram_blk_m != 0 && bytes >= uram_blk_m && uram_use + uneed <= uram_budget_m) begin
      uram_use += uneed;
      return KIND_URAM;
    end
    need = rounded_cost(copies, banks, bytes, bram_blk_m);
    if (bram_use + need <= bram_budget_m) begin
      bram_use += need;
      return KIND_BRAM;
    end
    if (uram_blk_m != 0 && bytes < uram_blk_m && uram_use + uneed <= uram_budget_m) begin
      uram_use += uneed;
      return KIND_URAM;
    end
    return KIND_DRAM;
  endfunction

  function automatic u64 sat32(u64 a, u64 b);
    return (a + b > Max32) ? Max32 : a + b;
  endfunction

  function automatic placement_t place_request(request_t r);
    placement_t p;
    u64 banks, bytes, copies, cost;
    logic [CurW-1:0] cur;
    logic rebal, allow_dram, decided;
    kind_t k;
    banks = (r.bank_count == 0) ? 64'd1 : u64'(r.bank_count);
    bytes = u64'(r.byte_size);
    copies = r.is_constant ? 64'd1 : 64'd2;
    cur = (r.current_kind > CUR_UNKNOWN) ? CUR_UNKNOWN : r.current_kind;
    rebal = mode_m[0];
    allow_dram = mode_m[1];
    k = KIND_BRAM;
    decided = 1'b0;
    if (r.start_run) begin
      lutram_use = 0; uram_use = 0; bram_use = 0;
      rebal_ovf = 0; const_ovf = 0; ext_ovf = 0;
    end
    if (rebal) begin
      if (cur == CUR_DRAM) begin
        k = KIND_DRAM;
        decided = 1'b1;
      end
    end else if (allow_dram && !r.is_constant && u64'(r.element_count) >= thresh_m) begin
      k = KIND_DRAM;
      decided = 1'b1;
    end
    if (!decided && bytes != 0) begin
      k = choose_tier(bytes, banks, copies);
      if (k == KIND_DRAM) begin
        cost = rounded_cost(copies, banks, bytes, bram_blk_m);
        if (rebal) begin
          k = (cur == CUR_UNKNOWN) ? KIND_BRAM : kind_t'(cur[1:0]);
          rebal_ovf = sat32(rebal_ovf, cost);
        end else if (r.is_constant) begin
          const_ovf = sat32(const_ovf, cost);
          k = KIND_BRAM;
        end else if (!allow_dram) begin
          ext_ovf = sat32(ext_ovf, cost);
          k = KIND_BRAM;
        end
      end
    end
    p.kind = k;
    p.lutram_used = lutram_use[31:0];
    p.uram_used = uram_use[31:0];
    p.bram_used = bram_use[31:0];
    p.rebal_ovf = rebal_ovf[31:0];
    p.const_ovf = const_ovf[31:0];
    p.ext_ovf = ext_ovf[31:0];
    return p;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= (stall_phase % 7) > 2;
      endcase
    end
  end

  // ---------------------------------------------------------------- checker
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    placement_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: response with no request pending: expected none, actual kind %0d",
                 $time, placed_kind);
      end else begin
        e = expected_q.pop_front();
        checked++;
        kind_hits[e.kind]++;
        check_field("placed_kind", 32'(e.kind), 32'(placed_kind));
        check_field("lutram_used_bytes", e.lutram_used, lutram_used_bytes);
        check_field("uram_used_bytes", e.uram_used, uram_used_bytes);
        check_field("bram_used_bytes", e.bram_used, bram_used_bytes);
        check_field("rebalance_overflow_bytes", e.rebal_ovf, rebalance_overflow_bytes);
        check_field("constant_overflow_bytes", e.const_ovf, constant_overflow_bytes);
        check_field("external_overflow_bytes", e.ext_ovf, external_overflow_bytes);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_request(request_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (max_gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, max_gap)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    start_run <= r.start_run;
    element_count <= r.element_count;
    byte_size <= r.byte_size;
    bank_count <= r.bank_count;
    is_constant <= r.is_constant;
    current_kind <= r.current_kind;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_q.push_back(place_request(r));
    sent++;
  endtask

  task automatic req(logic st, logic [31:0] el, logic [31:0] by, logic [12:0] bk,
                     logic cn, logic [2:0] cur);
    request_t r;
    r.start_run = st; r.element_count = el; r.byte_size = by;
    r.bank_count = bk; r.is_constant = cn; r.current_kind = cur;
    send_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_DRAM_THRESH:   thresh_m = value;
      REG_BRAM_BUDGET:   bram_budget_m = value;
      REG_URAM_BUDGET:   uram_budget_m = value;
      REG_LUTRAM_BUDGET: lutram_budget_m = value;
      REG_LUTRAM_MAX:    lutram_max_m = value;
      REG_BRAM_BLOCK:    bram_blk_m = value[BlkW-1:0];
      REG_URAM_BLOCK:    uram_blk_m = value[BlkW-1:0];
      REG_MODE:          mode_m = value[ModeW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] thr, logic [31:0] bb, logic [31:0] ub,
                           logic [31:0] lb, logic [31:0] lmax, logic [31:0] bblk,
                           logic [31:0] ublk, logic [31:0] mode);
    drain();
    write_reg(REG_DRAM_THRESH, thr);
    write_reg(REG_BRAM_BUDGET, bb);
    write_reg(REG_URAM_BUDGET, ub);
    write_reg(REG_LUTRAM_BUDGET, lb);
    write_reg(REG_LUTRAM_MAX, lmax);
    write_reg(REG_BRAM_BLOCK, bblk);
    write_reg(REG_URAM_BLOCK, ublk);
    write_reg(REG_MODE, mode);
    settings++;
  endtask

  // ---------------------------------------------------------------- random
  function automatic logic [31:0] pick_budget();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return Max32[31:0];
      2: return $urandom_range(1, 4096);
      default: return $urandom_range(65536, 32'd8_000_000);
    endcase
  endfunction

  function automatic logic [31:0] pick_block();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return $urandom;
      3: return 32'd4608;
      4: return 32'd36864;
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.start_run = ($urandom_range(0, 24) == 0);
    r.element_count = ($urandom_range(0, 2) == 0) ? $urandom
                      : 32'(thresh_m) + 32'($urandom_range(0, 8)) - 32'd4;
    case ($urandom_range(0, 9))
      0: r.byte_size = 32'd0;
      1: r.byte_size = $urandom;
      2: r.byte_size = Max32[31:0];
      3, 4: r.byte_size = $urandom_range(1, 512);
      5, 6: r.byte_size = $urandom_range(1, 100000);
      default: r.byte_size = $urandom_range(1, 2_000_000);
    endcase
    case ($urandom_range(0, 7))
      0: r.bank_count = 13'd0;
      1: r.bank_count = 13'($urandom);
      2, 3: r.bank_count = 13'($urandom_range(1, 16));
      default: r.bank_count = 13'd1;
    endcase
    r.is_constant = ($urandom_range(0, 2) == 0);
    r.current_kind = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    // all budgets are zero after reset: every sized buffer overflows
    req(1'b0, 32'd5, 32'd100, 13'd1, 1'b0, 3'd4);
    req(1'b0, 32'd5, 32'd40000, 13'd3, 1'b1, 3'd7);
    req(1'b0, 32'd5, 32'd0, 13'd1, 1'b0, 3'd3);
  endtask

  task automatic test_tier_order();
    configure(32'd0, 32'd100000, 32'd300000, 32'd1024, 32'd256, 32'd4608, 32'd36864, 32'd0);
    req(1'b1, 32'd1, 32'd256, 13'd1, 1'b0, 3'd0);      // lutram, takes two copies
    req(1'b0, 32'd1, 32'd200, 13'd1, 1'b0, 3'd0);      // lutram again, two copies still fit
    req(1'b0, 32'd1, 32'd40000, 13'd1, 1'b1, 3'd1);    // large: uram first
    req(1'b0, 32'd1, 32'd9000, 13'd0, 1'b0, 3'd2);     // zero banks
    req(1'b0, 32'd1, 32'd20000, 13'd8191, 1'b0, 3'd2); // many banks
    req(1'b0, 32'd1, 32'd30000, 13'd2, 1'b0, 3'd2);    // two banks: bram still fits
    req(1'b0, 32'd1, 32'hFFFF_FFFF, 13'd4096, 1'b1, 3'd4);
    req(1'b0, 32'd1, 32'hFFFF_FFFF, 13'd1, 1'b1, 3'd4); // constant overflow saturates
    req(1'b0, 32'd1, 32'hFFFF_FFFF, 13'd1, 1'b0, 3'd4); // external overflow
  endtask

  task automatic test_dram_threshold();
    configure(32'd0, 32'd100000, 32'd0, 32'd0, 32'd256, 32'd4608, 32'd36864, 32'd2);
    req(1'b1, 32'd0, 32'd100, 13'd1, 1'b0, 3'd2);           // threshold zero: dram
    req(1'b0, 32'd0, 32'd100, 13'd1, 1'b1, 3'd2);           // constant exempt
    configure(32'hFFFF_FFFF, 32'd10000, 32'd0, 32'd0, 32'd256, 32'd4608, 32'd0, 32'd2);
    req(1'b0, 32'hFFFF_FFFE, 32'd5000, 13'd1, 1'b0, 3'd2);  // below threshold, no bram room: spill
    req(1'b0, 32'hFFFF_FFFF, 32'd5000, 13'd1, 1'b0, 3'd2);  // at threshold
    req(1'b0, 32'd7, 32'd90000, 13'd1, 1'b0, 3'd2);         // no fit, spill
  endtask

  task automatic test_rebalance();
    configure(32'd0, 32'd9216, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    for (int c = 0; c < 8; c++) req(c == 0, 32'd1, 32'd6000, 13'd1, c[0], 3'(c));
    configure(32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h001F_FFFF, 32'hFFFF_FFFF, 32'd3);
    req(1'b0, 32'd0, 32'hFFFF_FFFF, 13'h1FFF, 1'b0, 3'd1);
  endtask

  task automatic test_backpressure();
    stall_style = 0;
    max_gap = 0;
    hold_left = 1500;
    for (int i = 0; i < 30; i++) send_request(random_request());
    drain();
  endtask

  task automatic test_random(int n_items);
    for (int s = 0; s < 9; s++) begin
      configure($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096),
                pick_budget(), pick_budget(), pick_budget(),
                $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1024),
                pick_block(), pick_block(), $urandom);
      stall_style = s % 3;
      max_gap = (s % 4 == 3) ? 0 : 8;
      for (int i = 0; i < n_items / 9; i++) send_request(random_request());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; start_run = 1'b0; element_count = '0; byte_size = '0;
    bank_count = 13'd1; is_constant = 1'b0; current_kind = '0;
    out_ready = 1'b0; cfg_we = 1'b0; cfg_index = REG_DRAM_THRESH; cfg_data = '0;
    thresh_m = 0; bram_budget_m = 0; uram_budget_m = 0; lutram_budget_m = 0;
    lutram_max_m = LUTRAM_MAX_RESET; bram_blk_m = BRAM_BLOCK_RESET;
    uram_blk_m = URAM_BLOCK_RESET; mode_m = 0;
    lutram_use = 0; uram_use = 0; bram_use = 0; rebal_ovf = 0; const_ovf = 0; ext_ovf = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_tier_order();
    test_dram_threshold();
    test_rebalance();
    test_backpressure();
    test_random(1350);

    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d requests over %0d register settings, %0d responses checked.",
             sent, settings, checked);
    $display("Tiers seen: lutram %0d, uram %0d, bram %0d, dram %0d.",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/bmtp_pkg.sv
src/bmtp_div.sv
src/budgeted_memory_tier_placer.sv
bench/testbench.sv
